// ===== hw/rtl/amcs_pkg.sv =====
// Package with shared types and constants for the MOV condition and shift unit.
`timescale 1ns / 1ps

package amcs_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned RegIdxW = 4;
  localparam int unsigned FlagsW = 4;
  localparam int unsigned ShAmtW = 5;

  // Instruction bit 4 selects a register-specified shift amount.
  localparam logic [5:0] ShiftRegBit = 6'b010000;
  // Mask for the immediate shift amount in bits 11..7.
  localparam logic [4:0] Imm5Mask = 5'b11111;

  // Condition codes.
  localparam logic [3:0] CondEq = 4'd0;
  localparam logic [3:0] CondNe = 4'd1;
  localparam logic [3:0] CondCs = 4'd2;
  localparam logic [3:0] CondCc = 4'd3;
  localparam logic [3:0] CondMi = 4'd4;
  localparam logic [3:0] CondPl = 4'd5;
  localparam logic [3:0] CondVs = 4'd6;
  localparam logic [3:0] CondVc = 4'd7;
  localparam logic [3:0] CondHi = 4'd8;
  localparam logic [3:0] CondLs = 4'd9;
  localparam logic [3:0] CondGe = 4'd10;
  localparam logic [3:0] CondLt = 4'd11;
  localparam logic [3:0] CondGt = 4'd12;
  localparam logic [3:0] CondLe = 4'd13;
  localparam logic [3:0] CondAl = 4'd14;
  localparam logic [3:0] CondNv = 4'd15;

  // Shift types.
  localparam logic [1:0] ShiftLsl = 2'd0;
  localparam logic [1:0] ShiftLsr = 2'd1;
  localparam logic [1:0] ShiftAsr = 2'd2;
  localparam logic [1:0] ShiftRor = 2'd3;

  // Mode field values.
  localparam logic ModeReg = 1'b0;
  localparam logic ModeImm = 1'b1;

  localparam logic [RegIdxW-1:0] PcIndex = 4'd15;

  typedef struct packed {
    logic               mode;
    logic [DataW-1:0]   instr;
    logic [FlagsW-1:0]  flags;
    logic [DataW-1:0]   rm_value;
    logic [DataW-1:0]   rs_value;
  } in_t;

  typedef struct packed {
    logic               executed;
    logic               write_enable;
    logic [RegIdxW-1:0] dest_index;
    logic [DataW-1:0]   write_value;
    logic               pc_written;
    logic               unsupported;
  } out_t;

endpackage

// ===== hw/rtl/arm_mov_condition_shift.sv =====
// Top level of the MOV execute unit: input register, execute logic, result register.
`timescale 1ns / 1ps

// This block executes one MOV instruction per request: the condition field is
// tested against the NZCV flags, and the operand is either a register value
// shifted LSL, LSR or ROR (by an immediate or by the low byte of Rs) or an 8-bit
// immediate rotated right by twice the rotate field. Each request gives exactly
// one result with the destination index, the value written, and flags telling
// whether the PC is written or an unsupported ASR shift was seen. The unit is a
// two-stage pipeline: a request is captured in the input register, goes through
// the condition check and barrel shifter, and lands in the result register once
// that register is empty or being drained. One request can be accepted every
// cycle while the result side keeps taking results; the rate is set by the single
// pass through the barrel shifter between the two registers. While the result
// side stalls, the result register holds its result and the input register can
// still take one request if it is empty.

module arm_mov_condition_shift (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  amcs_pkg::in_t  in_req_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output amcs_pkg::out_t out_rsp_o
);

  logic           s1_valid_q, s1_valid_d;
  amcs_pkg::in_t  s1_req_q;
  logic           s1_adv;
  logic           out_valid_q, out_valid_d;
  amcs_pkg::out_t out_rsp_q;
  amcs_pkg::out_t exec_rsp;

  // The input register moves into the result register whenever the result
  // register is empty or being drained this cycle.
  assign s1_adv     = !out_valid_q || out_ready_i;
  assign in_ready_o = !s1_valid_q || s1_adv;

  assign s1_valid_d  = (in_valid_i && in_ready_o) || (s1_valid_q && !s1_adv);
  assign out_valid_d = (s1_valid_q && s1_adv) || (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_req_q <= in_req_i;
    end
    if (s1_valid_q && s1_adv) begin
      out_rsp_q <= exec_rsp;
    end
  end

  amcs_exec u_exec (
    .req_i (s1_req_q),
    .rsp_o (exec_rsp)
  );

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

`ifndef SYNTHESIS
  // An accepted request always occupies the input register on the next cycle.
  a_accept_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> s1_valid_q)
    else $error("accepted request did not reach the input register");

  // A request waiting in the input register moves on once the result slot frees.
  a_stage_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && s1_adv) |=> out_valid_o)
    else $error("input register did not advance into the result register");

  // A PC write is only reported for an executed instruction with register 15 as destination.
  a_pc_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_rsp_o.pc_written) |->
      (out_rsp_o.executed && (out_rsp_o.dest_index == amcs_pkg::PcIndex)))
    else $error("pc_written without an executed write to the PC");

  // Nothing is written when the condition fails or the shift is unsupported.
  a_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (!out_rsp_o.executed || out_rsp_o.unsupported)) |->
      (!out_rsp_o.write_enable && (out_rsp_o.write_value == '0)))
    else $error("write reported for a skipped or unsupported instruction");
`endif

endmodule

// ===== hw/rtl/amcs_exec.sv =====
// Combinational condition check and barrel shifter for one MOV instruction.
`timescale 1ns / 1ps

module amcs_exec (
  input  amcs_pkg::in_t  req_i,
  output amcs_pkg::out_t rsp_o
);

  logic       flag_n, flag_z, flag_c, flag_v;
  logic [3:0] cond;
  logic       cond_pass;
  logic [1:0] shift_type;
  logic [7:0] shift_amt;
  logic       amt_big;
  logic [4:0] rot_amt;
  logic [2*amcs_pkg::DataW-1:0] rm_dbl;
  logic [2*amcs_pkg::DataW-1:0] imm_dbl;
  logic [2*amcs_pkg::DataW-1:0] rm_rot;
  logic [2*amcs_pkg::DataW-1:0] imm_rot;
  logic [amcs_pkg::DataW-1:0]   shifted;
  logic                         shift_ok;

  assign flag_n = req_i.flags[3];
  assign flag_z = req_i.flags[2];
  assign flag_c = req_i.flags[1];
  assign flag_v = req_i.flags[0];
  assign cond   = req_i.instr[31:28];

  always_comb begin
    unique case (cond)
      amcs_pkg::CondEq: cond_pass = flag_z;
      amcs_pkg::CondNe: cond_pass = !flag_z;
      amcs_pkg::CondCs: cond_pass = flag_c;
      amcs_pkg::CondCc: cond_pass = !flag_c;
      amcs_pkg::CondMi: cond_pass = flag_n;
      amcs_pkg::CondPl: cond_pass = !flag_n;
      amcs_pkg::CondVs: cond_pass = flag_v;
      amcs_pkg::CondVc: cond_pass = !flag_v;
      amcs_pkg::CondHi: cond_pass = flag_c && !flag_z;
      amcs_pkg::CondLs: cond_pass = !flag_c || flag_z;
      amcs_pkg::CondGe: cond_pass = (flag_n == flag_v);
      amcs_pkg::CondLt: cond_pass = (flag_n != flag_v);
      amcs_pkg::CondGt: cond_pass = !flag_z && (flag_n == flag_v);
      amcs_pkg::CondLe: cond_pass = flag_z || (flag_n != flag_v);
      amcs_pkg::CondAl: cond_pass = 1'b1;
      amcs_pkg::CondNv: cond_pass = 1'b0;
      default:          cond_pass = 1'b0;
    endcase
  end

  // Shift amount comes from Rs's low byte or from the 5-bit immediate.
  assign shift_type = req_i.instr[6:5];
  assign shift_amt  = (|(req_i.instr[5:0] & amcs_pkg::ShiftRegBit))
                      ? req_i.rs_value[7:0]
                      : {3'b000, req_i.instr[11:7] & amcs_pkg::Imm5Mask};
  assign amt_big    = |shift_amt[7:5];

  // Rotates are done as a right shift of the doubled word.
  assign rot_amt = shift_amt[4:0];
  assign rm_dbl  = {req_i.rm_value, req_i.rm_value};
  assign rm_rot  = rm_dbl >> rot_amt;
  assign imm_dbl = {2{24'd0, req_i.instr[7:0]}};
  assign imm_rot = imm_dbl >> {req_i.instr[11:8], 1'b0};

  always_comb begin
    shift_ok = 1'b1;
    case (shift_type)
      amcs_pkg::ShiftLsl: shifted = amt_big ? '0 : (req_i.rm_value << rot_amt);
      amcs_pkg::ShiftLsr: shifted = amt_big ? '0 : (req_i.rm_value >> rot_amt);
      amcs_pkg::ShiftRor: shifted = rm_rot[amcs_pkg::DataW-1:0];
      default: begin
        shifted  = '0;
        shift_ok = 1'b0;
      end
    endcase
  end

  always_comb begin
    rsp_o            = '0;
    rsp_o.dest_index = req_i.instr[15:12];
    if (cond_pass) begin
      rsp_o.executed   = 1'b1;
      rsp_o.pc_written = (req_i.instr[15:12] == amcs_pkg::PcIndex);
      if (req_i.mode == amcs_pkg::ModeImm) begin
        rsp_o.write_enable = 1'b1;
        rsp_o.write_value  = imm_rot[amcs_pkg::DataW-1:0];
      end else begin
        rsp_o.write_enable = shift_ok;
        rsp_o.unsupported  = !shift_ok;
        rsp_o.write_value  = shifted;
      end
    end
  end

endmodule

// ===== tb/arm_mov_condition_shift_tb.sv =====
// Self-checking testbench for the MOV condition check and barrel shift unit.
`timescale 1ns / 1ps

// The bench pushes directed and random MOV requests through the valid/ready
// request channel, predicts each result from the request alone, and compares
// every accepted result against the oldest prediction. The unit carries no state
// from one request to the next, so a prediction depends only on its own request.
module arm_mov_condition_shift_tb;
  import amcs_pkg::*;

  localparam int unsigned IdleLimit = 3000;
  localparam int unsigned LongHoldCycles = 300;
  localparam int unsigned NumRandomReqs = 650;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic in_valid = 1'b0;
  logic in_ready;
  in_t  in_req = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_rsp;

  // Requests waiting to be offered, and results predicted but not yet seen.
  in_t  pending_reqs[$];
  out_t mov_expected[$];

  int unsigned mismatch_count = 0;
  int unsigned idle_cycles = 0;

  // Sender burst bookkeeping.
  int unsigned burst_left = 8;
  int unsigned gap_left = 0;

  // Receiver stall bookkeeping.
  int unsigned rx_cycle = 0;
  int unsigned rx_mode = 0;
  int unsigned rx_mode_left = 0;
  int unsigned hold_left = 0;
  bit          hold_done = 1'b0;

  arm_mov_condition_shift dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_req_i   (in_req),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_rsp_o  (out_rsp)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Rotate right by 0..31; a rotate by zero returns the value unchanged.
  function automatic logic [DataW-1:0] rotate_right(logic [DataW-1:0] v, logic [4:0] n);
    logic [2*DataW-1:0] wide;
    wide = {v, v} >> n;
    return wide[DataW-1:0];
  endfunction

  // Standard condition-code test against N, Z, C, V. The never code fails.
  function automatic bit cond_holds(logic [3:0] cond, logic [FlagsW-1:0] nzcv);
    logic n, z, c, v;
    {n, z, c, v} = nzcv;
    case (cond)
      CondEq: return z;
      CondNe: return !z;
      CondCs: return c;
      CondCc: return !c;
      CondMi: return n;
      CondPl: return !n;
      CondVs: return v;
      CondVc: return !v;
      CondHi: return c && !z;
      CondLs: return !c || z;
      CondGe: return n == v;
      CondLt: return n != v;
      CondGt: return !z && (n == v);
      CondLe: return z || (n != v);
      CondAl: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  // Expected result of one MOV request.
  function automatic out_t predict_mov(in_t req);
    out_t        r;
    logic [7:0]  amt;
    logic [1:0]  kind;
    r = '0;
    r.dest_index = req.instr[15:12];
    if (cond_holds(req.instr[31:28], req.flags)) begin
      r.executed = 1'b1;
      r.pc_written = (r.dest_index == PcIndex);
      r.write_enable = 1'b1;
      if (req.mode == ModeImm) begin
        // The 4-bit rotate field counts in steps of two.
        r.write_value = rotate_right(DataW'(req.instr[7:0]), {req.instr[11:8], 1'b0});
      end else begin
        // A register amount uses the whole low byte of Rs, so it can exceed 31.
        if ((req.instr[5:0] & ShiftRegBit) != '0) begin
          amt = req.rs_value[7:0];
        end else begin
          amt = {3'b000, req.instr[11:7] & Imm5Mask};
        end
        kind = req.instr[6:5];
        case (kind)
          ShiftLsl: r.write_value = (amt >= 8'd32) ? '0 : req.rm_value << amt;
          ShiftLsr: r.write_value = (amt >= 8'd32) ? '0 : req.rm_value >> amt;
          ShiftRor: r.write_value = rotate_right(req.rm_value, amt[4:0]);
          default: begin
            // Arithmetic shifts are not implemented: flagged, nothing written.
            r.write_enable = 1'b0;
            r.unsupported = 1'b1;
          end
        endcase
      end
    end
    return r;
  endfunction

  task automatic queue_req(logic mode, logic [DataW-1:0] instr, logic [FlagsW-1:0] nzcv,
                           logic [DataW-1:0] rm, logic [DataW-1:0] rs);
    in_t req;
    req.mode = mode;
    req.instr = instr;
    req.flags = nzcv;
    req.rm_value = rm;
    req.rs_value = rs;
    pending_reqs.push_back(req);
  endtask

  // Register-form instruction word; the unused bits are filled at random.
  function automatic logic [DataW-1:0] reg_instr(logic [3:0] cond, logic [3:0] rd,
                                                 logic [1:0] kind, logic by_reg,
                                                 logic [4:0] imm5);
    return {cond, 12'($urandom), rd, imm5, kind, by_reg, 4'($urandom)};
  endfunction

  // Sender: requests go out in bursts of random length separated by random
  // gaps. A request that is offered stays on the bus, unchanged, until taken.
  // The next valid and payload are worked out first and assigned once.
  always @(posedge clk_i) begin
    logic next_valid;
    in_t  next_req;
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      next_valid = in_valid;
      next_req = in_req;
      if (in_valid && in_ready) begin
        next_valid = 1'b0;
      end
      if (!next_valid) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_reqs.size() > 0) begin
          next_req = pending_reqs.pop_front();
          next_valid = 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 32);
            // Some bursts run straight into the next one with no gap at all.
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
          end
        end
      end
      in_valid <= next_valid;
      in_req <= next_req;
    end
  end

  // Receiver: it switches between always ready, random ready, and ready whenever
  // its cycle count is a multiple of four. Once, early in the run, it holds off for a long stretch
  // while the sender keeps offering requests, so the pipeline fills and the
  // request side has to stall.
  always @(posedge clk_i) begin
    logic next_ready;
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else begin
      rx_cycle++;
      if (hold_left > 0) begin
        hold_left--;
        next_ready = 1'b0;
      end else if (!hold_done && rx_cycle >= 300) begin
        hold_done = 1'b1;
        hold_left = LongHoldCycles;
        next_ready = 1'b0;
      end else begin
        if (rx_mode_left == 0) begin
          rx_mode = $urandom_range(0, 2);
          rx_mode_left = $urandom_range(20, 80);
        end else begin
          rx_mode_left--;
        end
        case (rx_mode)
          0: next_ready = 1'b1;
          1: next_ready = 1'($urandom_range(0, 1));
          default: next_ready = (rx_cycle % 4 == 0);
        endcase
      end
      out_ready <= next_ready;
    end
  end

  // Checker: a request taken at this edge gets its prediction queued first,
  // then a result taken at this edge is compared with the oldest prediction.
  always @(posedge clk_i) begin
    out_t want;
    if (rst_ni) begin
      if (in_valid && in_ready) begin
        mov_expected.push_back(predict_mov(in_req));
      end
      if (out_valid && out_ready) begin
        if (mov_expected.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("%0t: result with no request outstanding: %p", $realtime, out_rsp);
          end
        end else begin
          want = mov_expected.pop_front();
          if (out_rsp.executed !== want.executed ||
              out_rsp.write_enable !== want.write_enable ||
              out_rsp.dest_index !== want.dest_index ||
              out_rsp.write_value !== want.write_value ||
              out_rsp.pc_written !== want.pc_written ||
              out_rsp.unsupported !== want.unsupported) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
              $display("%0t: result mismatch", $realtime);
              $display("  expected exe=%b we=%b rd=%0d val=%h pc=%b unsup=%b",
                       want.executed, want.write_enable, want.dest_index,
                       want.write_value, want.pc_written, want.unsupported);
              $display("  actual   exe=%b we=%b rd=%0d val=%h pc=%b unsup=%b",
                       out_rsp.executed, out_rsp.write_enable, out_rsp.dest_index,
                       out_rsp.write_value, out_rsp.pc_written, out_rsp.unsupported);
            end
          end
        end
      end
    end
  end

  // Watchdog: too many cycles in a row with nothing moving on either channel
  // means the unit has hung.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IdleLimit) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  initial begin
    logic [3:0] cond;
    // Every condition code once, with flags and immediate fields varying.
    for (int c = 0; c < 16; c++) begin
      queue_req(1'(c), {4'(c), 28'($urandom)}, 4'(c), $urandom, $urandom);
    end
    // Lower-or-same: C clear passes, C set with Z clear fails, both set passes.
    queue_req(ModeImm, {CondLs, 28'($urandom)}, 4'b0000, $urandom, $urandom);
    queue_req(ModeImm, {CondLs, 28'($urandom)}, 4'b0010, $urandom, $urandom);
    queue_req(ModeImm, {CondLs, 28'($urandom)}, 4'b0110, $urandom, $urandom);
    // Immediate shift by zero leaves the value alone; shift by 31 is the largest.
    queue_req(ModeReg, reg_instr(CondAl, 4'd1, ShiftLsl, 1'b0, 5'd0), 4'h0,
              32'hFFFF_FFFF, $urandom);
    queue_req(ModeReg, reg_instr(CondAl, 4'd2, ShiftLsr, 1'b0, 5'd31), 4'hF,
              32'h8000_0000, $urandom);
    // Register amounts of 32 and above: shifts clear, rotate wraps.
    queue_req(ModeReg, reg_instr(CondAl, 4'd3, ShiftLsl, 1'b1, 5'($urandom)), 4'h0,
              32'hFFFF_FFFF, 32'hFFFF_FF20);
    queue_req(ModeReg, reg_instr(CondAl, 4'd4, ShiftLsr, 1'b1, 5'($urandom)), 4'h0,
              32'hFFFF_FFFF, 32'h0000_00FF);
    queue_req(ModeReg, reg_instr(CondAl, 4'd5, ShiftRor, 1'b1, 5'($urandom)), 4'h0,
              32'h8000_0001, 32'h0000_0021);
    // Arithmetic shift into the PC: flagged unsupported, PC write still reported.
    queue_req(ModeReg, reg_instr(CondAl, PcIndex, ShiftAsr, 1'b0, 5'd4), 4'h0,
              $urandom, $urandom);
    // Largest rotate of a full immediate, into the PC.
    queue_req(ModeImm, {CondAl, 12'h000, PcIndex, 4'hF, 8'hFF}, 4'h0, '0, '0);

    // Random requests, half of them unconditional so most of them execute.
    // Register amounts are usually near the 32 boundary, sometimes anything.
    for (int i = 0; i < NumRandomReqs; i++) begin
      cond = ($urandom_range(0, 1) == 0) ? CondAl : 4'($urandom);
      queue_req(1'($urandom), {cond, 28'($urandom)}, 4'($urandom), $urandom,
                ($urandom_range(0, 3) == 0) ? $urandom
                                            : {24'($urandom), 8'($urandom_range(0, 40))});
    end

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_reqs.size() != 0 || in_valid) @(posedge clk_i);
    while (mov_expected.size() != 0) @(posedge clk_i);
    // Give any stray result time to show up.
    repeat (10) @(posedge clk_i);

    if (mismatch_count == 0 && mov_expected.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/amcs_pkg.sv
hw/rtl/amcs_exec.sv
hw/rtl/arm_mov_condition_shift.sv
tb/arm_mov_condition_shift_tb.sv
